// ===== sv/assert_macros.svh =====
// assertion macros shared by the parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define SFP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// condition must never be true outside reset
`define SFP_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
        else $error(msg);

`endif

// ===== sv/sfp_pkg.sv =====
// types and constants of the status frame parser
package sfp_pkg;

    localparam int MAX_FRAME_LENGTH = 32;
    localparam int LEN_W = $clog2(MAX_FRAME_LENGTH + 1);
    localparam int BYTE_W = 8;
    localparam int MODE_W = 3;
    localparam int HEAD_DEPTH = 3;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] MIN_LEN_BYTE = 8'd2;
    localparam logic [BYTE_W-1:0] MAX_LEN_BYTE = BYTE_W'(MAX_FRAME_LENGTH);
    localparam logic [LEN_W-1:0] STATUS_LENGTH = LEN_W'(3);
    localparam logic [MODE_W-1:0] TOP_MODE = 3'd4;

    localparam logic [BYTE_W-1:0] CMD_CONNECT = 8'd0;
    localparam logic [BYTE_W-1:0] CMD_LED = 8'd1;

    typedef enum logic [2:0] {
        PH_SYNC = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    typedef struct packed {
        logic              link_connected;
        logic [BYTE_W-1:0] host_led_bits;
        logic              frame_end;
        logic              status_applied;
    } t_result;

endpackage

// ===== sv/sfp_channels.sv =====
// valid/ready channel interfaces for receive bytes, results and configuration
interface sfp_rx_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_res_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              link_connected;
    logic [BYTE_W-1:0] host_led_bits;
    logic              frame_end;
    logic              status_applied;

    modport source (output valid, output link_connected, output host_led_bits,
                    output frame_end, output status_applied, input ready);
    modport sink (input valid, input link_connected, input host_led_bits,
                  input frame_end, input status_applied, output ready);
endinterface

interface sfp_cfg_if import sfp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] active_mode;

    modport source (output valid, output active_mode, input ready);
    modport sink (input valid, input active_mode, output ready);
endinterface

// ===== sv/sfp_parser.sv =====
// frame parser state, status flags and next-result logic
`include "assert_macros.svh"

module sfp_parser import sfp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [BYTE_W-1:0] i_rx_byte,
    input  logic              i_cfg_write,
    input  logic [MODE_W-1:0] i_cfg_mode,
    output t_result           o_result
);

    t_phase            r_phase, n_phase;
    logic [LEN_W-1:0]  r_exp_len, n_exp_len;
    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [BYTE_W-1:0] r_head [HEAD_DEPTH];
    logic [BYTE_W-1:0] n_head [HEAD_DEPTH];
    logic              r_connected, n_connected;
    logic [BYTE_W-1:0] r_led, n_led;
    logic [MODE_W-1:0] r_mode;
    logic [LEN_W-1:0]  pos_inc;
    logic              done;
    logic              applied;
    logic              mode_match;

    assign pos_inc = r_pos + LEN_W'(1);
    assign mode_match = (r_mode <= TOP_MODE) &&
                        (n_head[1] == {{(BYTE_W-MODE_W){1'b0}}, r_mode});

    always_comb begin
        for (int k = 0; k < HEAD_DEPTH; k++) begin
            n_head[k] = (r_phase == PH_DATA && r_pos == LEN_W'(k)) ? i_rx_byte : r_head[k];
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_exp_len   = r_exp_len;
        n_pos       = r_pos;
        n_connected = r_connected;
        n_led       = r_led;
        done        = 1'b0;
        applied     = 1'b0;
        unique case (r_phase)
            PH_SYNC: begin
                if (i_rx_byte == SYNC_BYTE) begin
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                if (i_rx_byte >= MIN_LEN_BYTE && i_rx_byte <= MAX_LEN_BYTE) begin
                    n_exp_len = i_rx_byte[LEN_W-1:0];
                    n_pos     = '0;
                    n_phase   = PH_DATA;
                end else if (i_rx_byte != SYNC_BYTE) begin
                    n_phase = PH_SYNC;
                end
            end
            PH_DATA: begin
                n_pos = pos_inc;
                if (pos_inc >= r_exp_len) begin
                    done    = 1'b1;
                    n_phase = PH_SYNC;
                    n_pos   = '0;
                    if (r_exp_len == STATUS_LENGTH && mode_match) begin
                        if (n_head[0] == CMD_CONNECT) begin
                            n_connected = (n_head[2] == '0);
                            applied     = 1'b1;
                        end else if (n_head[0] == CMD_LED) begin
                            n_led   = n_head[2];
                            applied = 1'b1;
                        end
                    end
                end
            end
            default: begin
                n_phase = PH_SYNC;
                n_pos   = '0;
            end
        endcase
    end

    assign o_result.link_connected = n_connected;
    assign o_result.host_led_bits  = n_led;
    assign o_result.frame_end      = done;
    assign o_result.status_applied = applied;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC;
            r_exp_len   <= '0;
            r_pos       <= '0;
            r_connected <= 1'b0;
            r_led       <= '0;
            r_mode      <= '0;
        end else begin
            if (i_cfg_write) begin
                r_mode      <= i_cfg_mode;
                r_connected <= 1'b0;
            end else if (i_accept) begin
                r_connected <= n_connected;
            end
            if (i_accept) begin
                r_phase   <= n_phase;
                r_exp_len <= n_exp_len;
                r_pos     <= n_pos;
                r_led     <= n_led;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            for (int k = 0; k < HEAD_DEPTH; k++) begin
                r_head[k] <= n_head[k];
            end
        end
    end

    `SFP_ASSERT(a_pos_below_len, i_clk, i_rst_n,
        (r_phase == PH_DATA) |-> (r_pos < r_exp_len), "payload position past frame length")
    `SFP_ASSERT(a_applied_at_end, i_clk, i_rst_n,
        o_result.status_applied |-> o_result.frame_end, "status applied without frame end")
    `SFP_ASSERT(a_end_resyncs, i_clk, i_rst_n,
        (i_accept && o_result.frame_end) |=> (r_phase == PH_SYNC && r_pos == '0),
        "frame end did not return to sync hunt")

endmodule

// ===== sv/sfp_out_reg.sv =====
// result register between the parser and the result channel
`include "assert_macros.svh"

module sfp_out_reg import sfp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

    `SFP_NEVER(a_no_overwrite, i_clk, i_rst_n,
        i_valid && o_ready && r_valid && !i_ready, "result overwritten while stalled")
    `SFP_ASSERT(a_beat_lands, i_clk, i_rst_n,
        (i_valid && o_ready) |=> r_valid, "accepted beat left no result")

endmodule

// ===== sv/status_frame_parser_top.sv =====
// top level of the sync/length framed status parser
// Each received byte beat yields one result beat, registered in the cycle after
// the byte is taken, and a new byte is taken every cycle while the result register
// is empty or being drained; the sustained rate is one byte per clock, set by the
// single result register behind the combinational parser. Results carry the link
// and LED flags after that byte, a frame-end pulse and a status-applied pulse.
// Configuration writes to active_mode are taken at any cycle, clear the connected
// flag, and must only be issued while no byte is still awaiting its result.
module status_frame_parser_top import sfp_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    sfp_rx_if.sink    i_rx,
    sfp_cfg_if.sink   i_cfg,
    sfp_res_if.source o_res
);

    logic    accept;
    logic    in_ready;
    t_result next_result;
    t_result out_result;

    assign i_rx.ready  = in_ready;
    assign i_cfg.ready = 1'b1;
    assign accept      = i_rx.valid && in_ready;

    sfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cfg_write (i_cfg.valid),
        .i_cfg_mode  (i_cfg.active_mode),
        .o_result    (next_result)
    );

    sfp_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_rx.valid),
        .o_ready  (in_ready),
        .i_result (next_result),
        .o_valid  (o_res.valid),
        .i_ready  (o_res.ready),
        .o_result (out_result)
    );

    assign o_res.link_connected = out_result.link_connected;
    assign o_res.host_led_bits  = out_result.host_led_bits;
    assign o_res.frame_end      = out_result.frame_end;
    assign o_res.status_applied = out_result.status_applied;

endmodule
